[rtl/ctsynth_pkg.sv]
// Shared types, constants and the quarter-wave sine function of the chirp tone synthesizer.
`timescale 1ns / 1ps

package ctsynth_pkg;

  // Sine magnitude is Q30 with 1.0 = 2^30, so it needs 31 bits.
  localparam int SINE_W   = 31;
  localparam int IDX_W    = 18;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_SLOPE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_SLOPE = 3'd6;

  typedef struct packed {
    logic              neg;
    logic [SINE_W-1:0] mag;
  } sine_out_t;

  // sin(pi/2 * y) for y in Q30 over [0, 1], odd polynomial, result clamped to 1.0.
  // Only evaluated at elaboration to fill the constant table.
  function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] p;
    y2 = (y * y) >> 30;
    p  = 64'd3832;
    p  = 64'd172273 - ((p * y2) >> 30);
    p  = 64'd5026994 - ((p * y2) >> 30);
    p  = 64'd85569306 - ((p * y2) >> 30);
    p  = 64'd693598668 - ((p * y2) >> 30);
    p  = 64'd1686629713 - ((p * y2) >> 30);
    p  = (p * y) >> 30;
    if (p > 64'd1073741824) begin
      p = 64'd1073741824;
    end
    return p[SINE_W-1:0];
  endfunction

endpackage

[rtl/ctsynth_sine_rom.sv]
// Quarter-wave sine table with quadrant folding and a registered read.
`timescale 1ns / 1ps

module ctsynth_sine_rom import ctsynth_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rd_en,
  input  logic [31:0] phase,
  output sine_out_t   sine
);

  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
  localparam int QTAB   = SINE_TABLE_DEPTH / 4 + 1;
  localparam int KW     = ADDR_W - 1;

  typedef logic [SINE_W-1:0] tab_t [QTAB];

  function automatic tab_t build_tab();
    tab_t t;
    for (int k = 0; k < QTAB; k++) begin
      t[k] = quarter_sine(64'(k) << (32 - ADDR_W));
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  logic [ADDR_W-1:0] idx;
  logic [1:0]        quad;
  logic [KW-1:0]     r_ext;
  logic [KW-1:0]     k_idx;

  assign idx   = phase[31 -: ADDR_W];
  assign quad  = idx[ADDR_W-1 -: 2];
  assign r_ext = {1'b0, idx[ADDR_W-3:0]};
  // Odd quadrants run the quarter wave backwards, from the peak down.
  assign k_idx = quad[0] ? (KW'(QTAB - 1) - r_ext) : r_ext;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sine.mag <= SINE_TAB[k_idx];
      sine.neg <= quad[1];
    end
  end

endmodule

[rtl/chirp_tone_synth_unit.sv]
// Top level of the linear chirp tone synthesizer with attack and release envelope.
`timescale 1ns / 1ps

// One accepted beat on the input channel produces one PCM sample on the output channel.
// A silent sample (delay, tail or finished tone) goes from S_EVAL straight to S_OUT;
// a sounding sample first passes S_ATT, S_REL, S_VOL, S_AMP and S_MAG for the chain of five
// products (attack, release, volume, envelope and sine) that all go through the one
// registered 17 x 31 bit multiplier. The input is ready again in the cycle after the
// result is loaded into the output register, which holds it until it is taken, so a new
// beat is accepted only once the previous sample has been loaded, and that load waits
// for the output to be free. There is no clearing pass after reset.
module chirp_tone_synth_unit import ctsynth_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int TAIL_SAMPLES     = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_pcm_sample,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_ATT  = 3'd2;
  localparam logic [2:0] S_REL  = 3'd3;
  localparam logic [2:0] S_VOL  = 3'd4;
  localparam logic [2:0] S_AMP  = 3'd5;
  localparam logic [2:0] S_MAG  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam logic [16:0] GAIN_ONE = 17'h10000;

  // Configuration registers.
  logic [30:0]        base_step_r;
  logic signed [20:0] sweep_step_r;
  logic [15:0]        duration_r;
  logic [15:0]        delay_r;
  logic [15:0]        volume_r;
  logic [15:0]        attack_slope_r;
  logic [15:0]        release_slope_r;

  // Voice state.
  logic [2:0]       state_r;
  logic [IDX_W-1:0] sample_index_r;
  logic [31:0]      phase_acc_r;
  logic [32:0]      phase_step_r;

  // Per-sample working registers.
  logic [15:0] n_r;
  logic        last_r;
  logic [16:0] att_r;
  logic [16:0] rel_r;
  logic [47:0] prod_r;
  logic [15:0] pcm_r;

  logic              out_valid_r;
  logic signed [15:0] out_pcm_r;
  logic              out_last_r;

  sine_out_t sine;

  logic [32:0]      sweep_ext;
  logic [32:0]      half_sweep;
  logic [IDX_W-1:0] total;
  logic [IDX_W-1:0] offset;
  logic             active;
  logic             is_last;
  logic             sounding;
  logic [16:0]      mul_a;
  logic [30:0]      mul_b;
  logic [60:0]      scaled_full;
  logic [14:0]      scaled;
  logic             out_free;

  assign sweep_ext  = {{12{sweep_step_r[20]}}, sweep_step_r};
  assign half_sweep = {sweep_ext[32], sweep_ext[32:1]};

  assign total    = IDX_W'(delay_r) + IDX_W'(duration_r) + IDX_W'(TAIL_SAMPLES);
  assign offset   = sample_index_r - IDX_W'(delay_r);
  assign active   = sample_index_r < total;
  assign is_last  = active && (sample_index_r == total - IDX_W'(1));
  assign sounding = active && (sample_index_r >= IDX_W'(delay_r))
                    && (offset < IDX_W'(duration_r));

  // mag * 32767 without a multiplier; only the top 15 bits survive the shift by 46.
  assign scaled_full = {prod_r[45:0], 15'b0} - {15'b0, prod_r[45:0]};
  assign scaled      = scaled_full[60:46];

  assign out_free = !out_valid_r || out_ready;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_pcm_sample = out_pcm_r;
  assign out_last       = out_last_r;

  ctsynth_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk   (clk),
    .rd_en (state_r == S_EVAL),
    .phase (phase_acc_r),
    .sine  (sine)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_EVAL: begin
        mul_a = {1'b0, offset[15:0]};
        mul_b = {15'b0, attack_slope_r};
      end
      S_ATT: begin
        mul_a = {1'b0, duration_r - n_r};
        mul_b = {15'b0, release_slope_r};
      end
      S_REL: begin
        mul_a = att_r;
        mul_b = {15'b0, volume_r};
      end
      S_VOL: begin
        mul_a = rel_r;
        mul_b = {15'b0, prod_r[31:16]};
      end
      S_AMP: begin
        mul_a = {1'b0, prod_r[31:16]};
        mul_b = sine.mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= {31'b0, mul_a} * {17'b0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_step_r     <= '0;
      sweep_step_r    <= '0;
      duration_r      <= 16'd1;
      delay_r         <= '0;
      volume_r        <= 16'd32768;
      attack_slope_r  <= 16'd124;
      release_slope_r <= 16'd37;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_STEP:     base_step_r     <= cfg_data[30:0];
        CFG_SWEEP_STEP:    sweep_step_r    <= cfg_data[20:0];
        CFG_DURATION:      duration_r      <= cfg_data[15:0];
        CFG_DELAY:         delay_r         <= cfg_data[15:0];
        CFG_VOLUME:        volume_r        <= cfg_data[15:0];
        CFG_ATTACK_SLOPE:  attack_slope_r  <= cfg_data[15:0];
        CFG_RELEASE_SLOPE: release_slope_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sample_index_r <= '0;
      phase_acc_r    <= '0;
      phase_step_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // In S_OUT the valid flag is either held or reloaded below.
      if (out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_restart) begin
              sample_index_r <= '0;
              phase_acc_r    <= '0;
              phase_step_r   <= {2'b0, base_step_r} + half_sweep;
            end
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          n_r    <= offset[15:0];
          last_r <= is_last;
          if (active) begin
            sample_index_r <= sample_index_r + IDX_W'(1);
          end
          if (sounding) begin
            phase_acc_r  <= phase_acc_r + phase_step_r[31:0];
            phase_step_r <= phase_step_r + sweep_ext;
            state_r      <= S_ATT;
          end else begin
            pcm_r   <= '0;
            state_r <= S_OUT;
          end
        end
        S_ATT: begin
          att_r   <= (prod_r[31:0] > 32'(GAIN_ONE)) ? GAIN_ONE : prod_r[16:0];
          state_r <= S_REL;
        end
        S_REL: begin
          rel_r   <= (prod_r[31:0] > 32'(GAIN_ONE)) ? GAIN_ONE : prod_r[16:0];
          state_r <= S_VOL;
        end
        S_VOL: begin
          state_r <= S_AMP;
        end
        S_AMP: begin
          state_r <= S_MAG;
        end
        S_MAG: begin
          pcm_r   <= sine.neg ? (16'd0 - {1'b0, scaled}) : {1'b0, scaled};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pcm_r   <= pcm_r;
            out_last_r  <= last_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The sine product never reaches the clamp at 1.0, so it fits in 46 bits.
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAG |-> prod_r[47:46] == 2'b00)
    else $error("sine product exceeds 46 bits");

  a_att_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_VOL |-> (att_r <= GAIN_ONE && rel_r <= GAIN_ONE))
    else $error("envelope gain above unity");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EVAL)
    else $error("accepted beat not evaluated");

  a_tail_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (TAIL_SAMPLES != 0) && out_valid && out_last |-> out_pcm_sample == 16'sd0)
    else $error("final sample of a tone with a tail is not silent");

endmodule

[dv/chirp_sample_checker.sv]
// Checker that predicts every PCM sample of the chirp tone synthesizer and compares the output beats.
`timescale 1ns / 1ps

module chirp_sample_checker import ctsynth_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int TAIL_LEN    = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_restart,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [15:0]   out_pcm_sample,
  input  logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   error_count,
  output int                   pending_samples,
  output int                   samples_checked,
  output int                   tone_ends
);

  localparam logic [63:0] Q30_ONE = 64'd1073741824;

  typedef struct packed {
    logic signed [15:0] pcm;
    logic               last;
  } chirp_sample_t;

  // Register copies, written from the configuration port.
  logic [30:0] r_base;
  logic [20:0] r_sweep;
  logic [15:0] r_dur;
  logic [15:0] r_delay;
  logic [15:0] r_vol;
  logic [15:0] r_att;
  logic [15:0] r_rel;

  // Voice state.
  logic [17:0] smp_idx;
  logic [31:0] acc;
  logic [32:0] step;

  chirp_sample_t expected_samples[$];
  int mismatches;
  int outstanding;
  int compared;
  int ends_seen;

  assign error_count     = mismatches;
  assign pending_samples = outstanding;
  assign samples_checked = compared;
  assign tone_ends       = ends_seen;

  function automatic logic [32:0] sweep_wide();
    return {{12{r_sweep[20]}}, r_sweep};
  endfunction

  function automatic void rewind_voice();
    logic [32:0] sw;
    sw = sweep_wide();
    smp_idx = '0;
    acc = '0;
    // Half of the sweep, rounded toward minus infinity.
    step = {2'b00, r_base} + {sw[32], sw[32:1]};
  endfunction

  // Odd polynomial for sin(pi/2 * y), y and result in Q30.
  function automatic logic [63:0] sine_poly_q30(input logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] p;
    y2 = (y * y) >> 30;
    p = 64'd3832;
    p = 64'd172273 - ((p * y2) >> 30);
    p = 64'd5026994 - ((p * y2) >> 30);
    p = 64'd85569306 - ((p * y2) >> 30);
    p = 64'd693598668 - ((p * y2) >> 30);
    p = 64'd1686629713 - ((p * y2) >> 30);
    p = (p * y) >> 30;
    return (p > Q30_ONE) ? Q30_ONE : p;
  endfunction

  function automatic logic signed [15:0] voice_level(input logic [63:0] n);
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] y;
    logic [63:0] s;
    logic [63:0] att;
    logic [63:0] rel;
    logic [63:0] amp;
    logic [63:0] mag;
    idx  = ({32'd0, acc} * 64'(TABLE_DEPTH)) >> 32;
    frac = ((idx << 32) / 64'(TABLE_DEPTH)) & 64'hFFFF_FFFF;
    quad = frac >> 30;
    r    = frac & (Q30_ONE - 64'd1);
    y    = quad[0] ? Q30_ONE - r : r;
    s    = sine_poly_q30(y);
    att  = n * {48'd0, r_att};
    rel  = ({48'd0, r_dur} - n) * {48'd0, r_rel};
    if (att > 64'd65536) begin
      att = 64'd65536;
    end
    if (rel > 64'd65536) begin
      rel = 64'd65536;
    end
    amp = ((({48'd0, r_vol} * att) >> 16) * rel) >> 16;
    mag = amp * s;
    if (mag > (64'd1 << 46)) begin
      mag = 64'd1 << 46;
    end
    mag = (mag * 64'd32767) >> 46;
    return quad[1] ? -$signed(mag[15:0]) : $signed(mag[15:0]);
  endfunction

  function automatic chirp_sample_t predict_sample(input logic restart);
    chirp_sample_t want;
    logic [17:0] total;
    total = 18'(r_delay) + 18'(r_dur) + 18'(TAIL_LEN);
    want = '0;
    if (restart) begin
      rewind_voice();
    end
    // Once the tail is over the voice stays silent until the next restart.
    if (smp_idx < total) begin
      want.last = (smp_idx == total - 18'd1);
      if (smp_idx >= 18'(r_delay) && (smp_idx - 18'(r_delay)) < 18'(r_dur)) begin
        want.pcm = voice_level(64'(smp_idx - 18'(r_delay)));
        acc = acc + step[31:0];
        step = step + sweep_wide();
      end
      smp_idx = smp_idx + 18'd1;
    end
    return want;
  endfunction

  always @(posedge clk) begin : watch
    chirp_sample_t want;
    if (!rst_n) begin
      r_base  = '0;
      r_sweep = '0;
      r_dur   = 16'd1;
      r_delay = '0;
      r_vol   = 16'd32768;
      r_att   = 16'd124;
      r_rel   = 16'd37;
      rewind_voice();
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_STEP:     r_base  = cfg_data[30:0];
          CFG_SWEEP_STEP:    r_sweep = cfg_data[20:0];
          CFG_DURATION:      r_dur   = cfg_data[15:0];
          CFG_DELAY:         r_delay = cfg_data[15:0];
          CFG_VOLUME:        r_vol   = cfg_data[15:0];
          CFG_ATTACK_SLOPE:  r_att   = cfg_data[15:0];
          CFG_RELEASE_SLOPE: r_rel   = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected output beat: pcm_sample %0d last %0b", out_pcm_sample, out_last);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          compared++;
          if (out_last) begin
            ends_seen++;
          end
          if (out_pcm_sample !== want.pcm) begin
            $error("pcm_sample mismatch: expected %0d, actual %0d", want.pcm, out_pcm_sample);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, out_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_samples.push_back(predict_sample(in_restart));
      end
    end
    outstanding = expected_samples.size();
  end

endmodule

[dv/tb_chirp_tone_synth_unit.sv]
// Top of the chirp tone synthesizer testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module tb_chirp_tone_synth_unit import ctsynth_pkg::*; ();

  localparam int TABLE_DEPTH = 1024;
  localparam int TAIL_LEN    = 20;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam longint LIMIT_NS = 64'd3_000_000;
  // No register sits at this index; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_restart = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic signed [15:0]   out_pcm_sample;
  logic                 out_last;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  int chk_errors;
  int chk_pending;
  int chk_compared;
  int chk_ends;

  int send_idle_pct = 13;
  int recv_idle_pct = 86;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int sent_ticks    = 0;
  int settings_used = 0;
  int cur_dur       = 1;
  int cur_delay     = 0;

  chirp_tone_synth_unit #(
    .SINE_TABLE_DEPTH(TABLE_DEPTH),
    .TAIL_SAMPLES    (TAIL_LEN)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pcm_sample(out_pcm_sample),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  chirp_sample_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .TAIL_LEN   (TAIL_LEN)
  ) u_sample_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pcm_sample (out_pcm_sample),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .error_count    (chk_errors),
    .pending_samples(chk_pending),
    .samples_checked(chk_compared),
    .tone_ends      (chk_ends)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  always @(negedge clk) begin
    if (hold_left == 0 && holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_tick(input logic restart);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_restart <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    sent_ticks++;
  endtask

  // Stop offering beats and wait until every predicted sample has been taken.
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DURATION) begin
      cur_dur = int'(val[15:0]);
    end
    if (idx == CFG_DELAY) begin
      cur_delay = int'(val[15:0]);
    end
  endtask

  // Upper data bits above each register's width are random; the block must drop them.
  task automatic write_setting(input logic [30:0] base, input logic [20:0] sweep,
                               input logic [15:0] dur, input logic [15:0] dly,
                               input logic [15:0] vol, input logic [15:0] att,
                               input logic [15:0] rel);
    settle_idle();
    write_reg(CFG_BASE_STEP, base);
    write_reg(CFG_SWEEP_STEP, {10'($urandom), sweep});
    write_reg(CFG_DURATION, {15'($urandom), dur});
    write_reg(CFG_DELAY, {15'($urandom), dly});
    write_reg(CFG_VOLUME, {15'($urandom), vol});
    write_reg(CFG_ATTACK_SLOPE, {15'($urandom), att});
    write_reg(CFG_RELEASE_SLOPE, {15'($urandom), rel});
    settings_used++;
  endtask

  function automatic logic [15:0] pick_slope();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      return 16'h0000;
    end else if (sel == 1) begin
      return 16'hFFFF;
    end else if (sel < 6) begin
      // Slow enough that the ramp is visible over a short tone.
      return 16'($urandom_range(1, 3000));
    end
    return 16'($urandom);
  endfunction

  task automatic random_setting();
    logic [30:0] base;
    logic [15:0] dur;
    logic [15:0] dly;
    logic [15:0] vol;
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      dur = 16'd0;
    end else if (sel == 1) begin
      dur = 16'hFFFF;
    end else if (sel == 2) begin
      dur = 16'($urandom);
    end else begin
      dur = 16'($urandom_range(1, 24));
    end
    dly = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    sel = $urandom_range(9);
    vol = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom);
    base = ($urandom_range(1) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 26));
    write_setting(base, 21'($urandom), dur, dly, vol, pick_slope(), pick_slope());
  endtask

  task automatic send_run(input int count, input int restart_pct);
    for (int i = 0; i < count; i++) begin
      send_tick($urandom_range(99) < restart_pct);
    end
  endtask

  // A restart followed by the whole tone plus extra beats, or part of it when the tone is long.
  task automatic play_tone(input int extra, input bit broken);
    int total;
    int count;
    total = cur_delay + cur_dur + TAIL_LEN;
    count = (total > 60) ? $urandom_range(8, 40) : total + extra;
    send_tick(1'b1);
    for (int i = 1; i < count; i++) begin
      send_tick(broken && $urandom_range(15) == 0);
    end
  endtask

  initial begin
    #(LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int goal[3];
    int sel;
    goal[0] = 200;
    goal[1] = 380;
    goal[2] = 540;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The voice plays from reset without any restart first.
    send_run(2, 0);
    write_setting(31'h7FFF_FFFF, 21'h100000, 16'd4, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(CFG_SPARE_IDX, 31'h7FFF_FFFF);
    play_tone(0, 1'b0);
    settle_idle();
    write_setting(31'd0, 21'h0FFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    send_run(1, 100);
    send_run(3, 0);
    // Zero duration with the longest delay: only silence.
    write_setting(31'h0123_4567, 21'h000155, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_run(1, 100);
    send_run(2, 0);
    write_setting(31'h0123_4567, 21'd1000, 16'd3, 16'd0, 16'd40000, 16'd30000, 16'd20000);
    send_run(1, 100);
    send_run(2, 0);
    // Register changes in the middle of a tone; the new base step waits for a restart.
    settle_idle();
    write_reg(CFG_VOLUME, 31'h0000_FFFF);
    write_reg(CFG_BASE_STEP, 31'h2000_0000);
    send_run(3, 0);

    for (int phase = 0; phase < 3; phase++) begin
      settle_idle();
      @(posedge clk);
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 13 : 0;
      if (phase == 2) begin
        // Keep offering beats while the receiver holds off, so the block backs up.
        random_setting();
        @(posedge clk);
        hold_requests++;
        send_run(40, 5);
      end
      while (sent_ticks < goal[phase]) begin
        sel = $urandom_range(9);
        if (sel < 7) begin
          random_setting();
          play_tone($urandom_range(0, 3), $urandom_range(3) == 0);
        end else if (sel == 7) begin
          settle_idle();
          write_reg(CFG_VOLUME, 31'($urandom));
          write_reg(CFG_RELEASE_SLOPE, 31'($urandom_range(0, 3000)));
          send_run($urandom_range(3, 15), 0);
        end else if (sel == 8) begin
          send_run($urandom_range(1, 10), 30);
        end else begin
          random_setting();
          send_run($urandom_range(3, 20), 0);
        end
      end
    end

    settle_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d tick beats over %0d register settings and three handshake phases;",
             sent_ticks, settings_used);
    $display("compared %0d samples, %0d of them tone ends.", chk_compared, chk_ends);
    if (chk_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
